/* rtl/cbb_pkg.sv */
// shared types, constants and helpers for the billboard camera frame pipeline
// no dependencies
package cbb_pkg;

  // configuration register indexes
  localparam logic [1:0] RegUpX = 2'd0;
  localparam logic [1:0] RegUpY = 2'd1;
  localparam logic [1:0] RegUpZ = 2'd2;

  localparam logic signed [31:0] UpXReset = 32'sd0;
  localparam logic signed [31:0] UpYReset = 32'sd65536;
  localparam logic signed [31:0] UpZReset = 32'sd0;

  // normalizer geometry
  localparam int unsigned MagW   = 63;  // input magnitude width
  localparam int unsigned AW     = 30;  // scaled magnitude width
  localparam int unsigned SumW   = 62;  // sum of three squares
  localparam int unsigned RootW  = 31;  // square root width
  localparam int unsigned QuoW   = 17;  // quotient bits before saturation

  typedef logic signed [15:0] q15_t;

  typedef struct packed {
    q15_t x;
    q15_t y;
    q15_t z;
  } vec15_t;

  // round Q2.30 to Q1.15 half away from zero, saturate
  function automatic q15_t q30to15(input logic signed [33:0] v);
    logic [33:0] m;
    logic [33:0] q;
    begin
      m = v[33] ? (~v + 34'd1) : v;
      q = (m + 34'd16384) >> 15;
      if (v[33]) begin
        q30to15 = (q > 34'd32768) ? 16'sh8000 : q15_t'(~q[15:0] + 16'd1);
      end else begin
        q30to15 = (q > 34'd32767) ? 16'sh7fff : q15_t'(q[15:0]);
      end
    end
  endfunction

endpackage

/* rtl/cbb_norm.sv */
// three-component normalizer to Q1.15: scale, square sum, root, divide, all pipelined
// depends on cbb_pkg
module cbb_norm (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic signed [cbb_pkg::MagW:0] v_x_i,
  input  logic signed [cbb_pkg::MagW:0] v_y_i,
  input  logic signed [cbb_pkg::MagW:0] v_z_i,
  input  logic                         valid_i,
  input  logic [127:0]                 side_i,
  output cbb_pkg::vec15_t              vec_o,
  output logic                         zero_o,
  output logic                         valid_o,
  output logic [127:0]                 side_o
);

  localparam int unsigned AW   = cbb_pkg::AW;
  localparam int unsigned SumW = cbb_pkg::SumW;
  localparam int unsigned RW   = cbb_pkg::RootW;
  localparam int unsigned QW   = cbb_pkg::QuoW;
  localparam int unsigned NS   = RW;  // root stages, one bit each
  localparam int unsigned NQ   = QW;  // divide stages, one bit each

  // stage 0: magnitudes and signs
  logic [cbb_pkg::MagW-1:0] m_q [3];
  logic [2:0]   s_q;
  logic         v0_q;
  logic [127:0] sd0_q;

  logic [cbb_pkg::MagW-1:0] m_d [3];
  always_comb begin
    m_d[0] = v_x_i[cbb_pkg::MagW] ? cbb_pkg::MagW'(-v_x_i) : v_x_i[cbb_pkg::MagW-1:0];
    m_d[1] = v_y_i[cbb_pkg::MagW] ? cbb_pkg::MagW'(-v_y_i) : v_y_i[cbb_pkg::MagW-1:0];
    m_d[2] = v_z_i[cbb_pkg::MagW] ? cbb_pkg::MagW'(-v_z_i) : v_z_i[cbb_pkg::MagW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q   <= m_d;
      s_q   <= {v_z_i[cbb_pkg::MagW], v_y_i[cbb_pkg::MagW], v_x_i[cbb_pkg::MagW]};
      sd0_q <= side_i;
    end
  end

  // stage 1: find leading one of the max, shift all so that the max lies in [2^29, 2^30)
  logic [cbb_pkg::MagW-1:0] mx;
  logic [5:0] lead;
  logic [AW-1:0] a_d [3];
  always_comb begin
    mx = m_q[0] | m_q[1] | m_q[2];
    lead = '0;
    for (int i = 0; i < cbb_pkg::MagW; i++) begin
      if (mx[i]) lead = 6'(i);
    end
    for (int k = 0; k < 3; k++) begin
      if (lead >= 6'(AW - 1)) begin
        a_d[k] = AW'(m_q[k] >> (lead - 6'(AW - 1)));
      end else begin
        a_d[k] = AW'(m_q[k] << (6'(AW - 1) - lead));
      end
    end
  end

  logic [AW-1:0] a_q [3];
  logic [2:0]    s1_q;
  logic          z1_q, v1_q;
  logic [127:0]  sd1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= v0_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q   <= a_d;
      s1_q  <= s_q;
      z1_q  <= (mx == '0);
      sd1_q <= sd0_q;
    end
  end

  // stage 2: squares
  logic [2*AW-1:0] sq_q [3];
  logic [AW-1:0]   a2_q [3];
  logic [2:0]      s2_q;
  logic            z2_q, v2_q;
  logic [127:0]    sd2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        sq_q[k] <= a_q[k] * a_q[k];
      end
      a2_q  <= a_q;
      s2_q  <= s1_q;
      z2_q  <= z1_q;
      sd2_q <= sd1_q;
    end
  end

  // stage 3: sum of squares
  logic [SumW-1:0] sum_q;
  logic [AW-1:0]   a3_q [3];
  logic [2:0]      s3_q;
  logic            z3_q, v3_q;
  logic [127:0]    sd3_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= SumW'(sq_q[0]) + SumW'(sq_q[1]) + SumW'(sq_q[2]);
      a3_q  <= a2_q;
      s3_q  <= s2_q;
      z3_q  <= z2_q;
      sd3_q <= sd2_q;
    end
  end

  // root pipeline: one result bit per stage, by trial squaring of each candidate bit
  logic [SumW-1:0] rr_q  [NS+1];
  logic [RW-1:0]   rt_q  [NS+1];
  logic [AW-1:0]   ra_q  [NS+1][3];
  logic [2:0]      rs_q  [NS+1];
  logic            rz_q  [NS+1];
  logic            rv_q  [NS+1];
  logic [127:0]    rsd_q [NS+1];

  always_comb begin
    rr_q[0]  = sum_q;
    rt_q[0]  = '0;
    ra_q[0]  = a3_q;
    rs_q[0]  = s3_q;
    rz_q[0]  = z3_q;
    rv_q[0]  = v3_q;
    rsd_q[0] = sd3_q;
  end

  for (genvar g = 0; g < NS; g++) begin : g_root
    localparam int unsigned B = NS - 1 - g;
    logic [SumW+1:0] trial;
    logic [RW-1:0]   cand;
    always_comb begin
      cand  = rt_q[g] | (RW'(1) << B);
      trial = (SumW+2)'(cand) * (SumW+2)'(cand);
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rv_q[g+1] <= 1'b0;
      end else if (en_i) begin
        rv_q[g+1] <= rv_q[g];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rt_q[g+1]  <= (trial <= (SumW+2)'(rr_q[g])) ? cand : rt_q[g];
        rr_q[g+1]  <= rr_q[g];
        ra_q[g+1]  <= ra_q[g];
        rs_q[g+1]  <= rs_q[g];
        rz_q[g+1]  <= rz_q[g];
        rsd_q[g+1] <= rsd_q[g];
      end
    end
  end

  // divide pipeline: q = (a*65536 + len) / (2*len), one quotient bit a stage
  localparam int unsigned NW = AW + 17;
  localparam int unsigned DW = RW + 1;
  logic [NW-1:0] dn_q [NQ+1][3];
  logic [QW-1:0] dq_q [NQ+1][3];
  logic [DW-1:0] dd_q [NQ+1];
  logic [2:0]    ds_q [NQ+1];
  logic          dz_q [NQ+1];
  logic          dv_q [NQ+1];
  logic [127:0]  dsd_q [NQ+1];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dn_q[0][k] = (NW'(ra_q[NS][k]) << 16) + NW'(rt_q[NS]);
      dq_q[0][k] = '0;
    end
    dd_q[0]  = {rt_q[NS], 1'b0};
    ds_q[0]  = rs_q[NS];
    dz_q[0]  = rz_q[NS];
    dv_q[0]  = rv_q[NS];
    dsd_q[0] = rsd_q[NS];
  end

  for (genvar g = 0; g < NQ; g++) begin : g_div
    localparam int unsigned B = NQ - 1 - g;
    logic [NW-1:0] rem_d [3];
    logic [QW-1:0] quo_d [3];
    logic [NW+QW-1:0] sub;
    always_comb begin
      sub = '0;
      for (int k = 0; k < 3; k++) begin
        sub = (NW+QW)'(dd_q[g]) << B;
        if ((NW+QW)'(dn_q[g][k]) >= sub) begin
          rem_d[k] = dn_q[g][k] - NW'(sub);
          quo_d[k] = dq_q[g][k] | (QW'(1) << B);
        end else begin
          rem_d[k] = dn_q[g][k];
          quo_d[k] = dq_q[g][k];
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[g+1] <= 1'b0;
      end else if (en_i) begin
        dv_q[g+1] <= dv_q[g];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dn_q[g+1]  <= rem_d;
        dq_q[g+1]  <= quo_d;
        dd_q[g+1]  <= dd_q[g];
        ds_q[g+1]  <= ds_q[g];
        dz_q[g+1]  <= dz_q[g];
        dsd_q[g+1] <= dsd_q[g];
      end
    end
  end

  // sign and saturation
  function automatic cbb_pkg::q15_t sat(input logic [QW-1:0] q, input logic neg);
    begin
      if (neg) begin
        sat = (q > QW'(32768)) ? 16'sh8000 : cbb_pkg::q15_t'(~q[15:0] + 16'd1);
      end else begin
        sat = (q > QW'(32767)) ? 16'sh7fff : cbb_pkg::q15_t'(q[15:0]);
      end
    end
  endfunction

  assign vec_o.x = sat(dq_q[NQ][0], ds_q[NQ][0]);
  assign vec_o.y = sat(dq_q[NQ][1], ds_q[NQ][1]);
  assign vec_o.z = sat(dq_q[NQ][2], ds_q[NQ][2]);
  assign zero_o  = dz_q[NQ];
  assign valid_o = dv_q[NQ];
  assign side_o  = dsd_q[NQ];

endmodule

/* rtl/camera_billboard_basis.sv */
// Billboard camera frame: a fully pipelined datapath that takes one eye/target
// transaction per cycle unless a held result stalls the output, and returns Z, X
// and Y axes in Q1.15 through two normalizers of 52 stages each, set by the
// one-bit-per-stage square root and divide, plus three cross product and output stages.
// A stall on a valid output freezes the whole pipeline; nothing is lost.
// Depends on cbb_pkg and cbb_norm.
module camera_billboard_basis (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] eye_x_i,
  input  logic signed [31:0] eye_y_i,
  input  logic signed [31:0] eye_z_i,
  input  logic signed [31:0] target_x_i,
  input  logic signed [31:0] target_y_i,
  input  logic signed [31:0] target_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] right_x_o,
  output logic signed [15:0] right_y_o,
  output logic signed [15:0] right_z_o,
  output logic signed [15:0] upward_x_o,
  output logic signed [15:0] upward_y_o,
  output logic signed [15:0] upward_z_o,
  output logic signed [15:0] forward_x_o,
  output logic signed [15:0] forward_y_o,
  output logic signed [15:0] forward_z_o,
  output logic               degenerate_o
);

  logic signed [31:0] up_x_q, up_y_q, up_z_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_x_q <= cbb_pkg::UpXReset;
      up_y_q <= cbb_pkg::UpYReset;
      up_z_q <= cbb_pkg::UpZReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cbb_pkg::RegUpX: up_x_q <= cfg_data_i;
        cbb_pkg::RegUpY: up_y_q <= cfg_data_i;
        cbb_pkg::RegUpZ: up_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // whole pipeline advances unless a finished result is held
  logic en;
  assign en = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // view vector difference
  logic signed [cbb_pkg::MagW:0] dx, dy, dz;
  assign dx = 64'(target_x_i) - 64'(eye_x_i);
  assign dy = 64'(target_y_i) - 64'(eye_y_i);
  assign dz = 64'(target_z_i) - 64'(eye_z_i);

  cbb_pkg::vec15_t z_vec;
  logic            z_zero, z_valid;
  logic [127:0]    z_side;

  cbb_norm u_norm_z (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .v_x_i   (dx),
    .v_y_i   (dy),
    .v_z_i   (dz),
    .valid_i (in_valid_i),
    .side_i  ('0),
    .vec_o   (z_vec),
    .zero_o  (z_zero),
    .valid_o (z_valid),
    .side_o  (z_side)
  );

  // cross product up x Z, products registered then differenced
  logic signed [47:0] p_q [6];
  cbb_pkg::vec15_t    zc_q;
  logic               degc_q, vc_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (en) begin
      vc_q <= z_valid;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q[0] <= up_y_q * z_vec.z;
      p_q[1] <= up_z_q * z_vec.y;
      p_q[2] <= up_z_q * z_vec.x;
      p_q[3] <= up_x_q * z_vec.z;
      p_q[4] <= up_x_q * z_vec.y;
      p_q[5] <= up_y_q * z_vec.x;
      zc_q   <= z_vec;
      degc_q <= z_zero || (up_x_q == '0 && up_y_q == '0 && up_z_q == '0);
    end
  end

  logic signed [cbb_pkg::MagW:0] cx, cy, cz;
  assign cx = 64'(p_q[0]) - 64'(p_q[1]);
  assign cy = 64'(p_q[2]) - 64'(p_q[3]);
  assign cz = 64'(p_q[4]) - 64'(p_q[5]);

  cbb_pkg::vec15_t x_vec;
  logic            x_zero, x_valid;
  logic [127:0]    x_side;

  cbb_norm u_norm_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .v_x_i   (cx),
    .v_y_i   (cy),
    .v_z_i   (cz),
    .valid_i (vc_q),
    .side_i  ({79'd0, degc_q, zc_q}),
    .vec_o   (x_vec),
    .zero_o  (x_zero),
    .valid_o (x_valid),
    .side_o  (x_side)
  );

  cbb_pkg::vec15_t zx;
  logic            degx;
  assign zx   = x_side[47:0];
  assign degx = x_side[48] | x_zero;

  // Y = Z x X products
  logic signed [31:0] yp_q [6];
  cbb_pkg::vec15_t    zy_q, xy_q;
  logic               degy_q, vy_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vy_q <= 1'b0;
    end else if (en) begin
      vy_q <= x_valid;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      yp_q[0] <= zx.y * x_vec.z;
      yp_q[1] <= zx.z * x_vec.y;
      yp_q[2] <= zx.z * x_vec.x;
      yp_q[3] <= zx.x * x_vec.z;
      yp_q[4] <= zx.x * x_vec.y;
      yp_q[5] <= zx.y * x_vec.x;
      zy_q    <= zx;
      xy_q    <= x_vec;
      degy_q  <= degx;
    end
  end

  // output register
  logic               vo_q, dego_q;
  cbb_pkg::vec15_t    xo_q, yo_q, zo_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en) begin
      vo_q <= vy_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      dego_q <= degy_q;
      if (degy_q) begin
        xo_q <= '0;
        yo_q <= '0;
        zo_q <= '0;
      end else begin
        xo_q   <= xy_q;
        zo_q   <= zy_q;
        yo_q.x <= cbb_pkg::q30to15(34'(yp_q[0]) - 34'(yp_q[1]));
        yo_q.y <= cbb_pkg::q30to15(34'(yp_q[2]) - 34'(yp_q[3]));
        yo_q.z <= cbb_pkg::q30to15(34'(yp_q[4]) - 34'(yp_q[5]));
      end
    end
  end

  assign out_valid_o  = vo_q;
  assign right_x_o    = xo_q.x;
  assign right_y_o    = xo_q.y;
  assign right_z_o    = xo_q.z;
  assign upward_x_o   = yo_q.x;
  assign upward_y_o   = yo_q.y;
  assign upward_z_o   = yo_q.z;
  assign forward_x_o  = zo_q.x;
  assign forward_y_o  = zo_q.y;
  assign forward_z_o  = zo_q.z;
  assign degenerate_o = dego_q;

endmodule
